@@ src/sfd_pkg.sv @@
// Shared types, constants and kernel arithmetic of the four-direction edge detector.
package sfd_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int DEF_WIDTH  = 640;
  localparam int DEF_HEIGHT = 480;
  localparam int MIN_SIZE   = 3;

  localparam int PIX_W  = 8;
  localparam int CFG_W  = 12;
  localparam int CFG_IW = 1;
  localparam int SUM_W  = 11;
  localparam int MAG_W  = 10;

  localparam logic [CFG_IW-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IW-1:0] REG_HEIGHT = 1'b1;

  localparam logic [MAG_W-1:0] EDGE_MAX = 10'd255;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [8:0][PIX_W-1:0] window_t;
  typedef logic [MAG_W-1:0] mag_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  // Horizontal, vertical and the two diagonal kernels, row-major, top-left first.
  localparam logic signed [2:0] KERNEL [4][9] = '{
    '{-3'sd1,  3'sd0,  3'sd1, -3'sd2,  3'sd0,  3'sd2, -3'sd1,  3'sd0,  3'sd1},
    '{-3'sd1, -3'sd2, -3'sd1,  3'sd0,  3'sd0,  3'sd0,  3'sd1,  3'sd2,  3'sd1},
    '{-3'sd2, -3'sd1,  3'sd0, -3'sd1,  3'sd0,  3'sd1,  3'sd0,  3'sd1,  3'sd2},
    '{ 3'sd0, -3'sd1, -3'sd2,  3'sd1,  3'sd0, -3'sd1,  3'sd2,  3'sd1,  3'sd0}
  };

  function automatic sum_t kernel_response(input window_t w, input int k);
    sum_t acc;
    sum_t term;
    acc = '0;
    for (int t = 0; t < 9; t++) begin
      term = SUM_W'($signed({3'b000, w[t]}) * KERNEL[k][t]);
      acc  = acc + term;
    end
    return acc;
  endfunction

  // The largest response is 4 * 255, so the magnitude fits in ten bits.
  function automatic mag_t magnitude(input sum_t v);
    sum_t neg;
    neg = -v;
    return v[SUM_W-1] ? neg[MAG_W-1:0] : v[MAG_W-1:0];
  endfunction

endpackage

@@ src/sfd_line_ram.sv @@
// Line store memory: one write port and one registered read port.
module sfd_line_ram #(
  parameter int DEPTH  = sfd_pkg::MAX_WIDTH,
  parameter int DATA_W = 2 * sfd_pkg::PIX_W
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/sfd_grad.sv @@
// Gradient stages: four kernel magnitudes, then maximum, clamp and output register.
module sfd_grad (
  input  logic             clk,
  input  logic             rst,
  input  logic             win_valid,
  input  logic             win_last,
  input  sfd_pkg::window_t win,
  output logic             win_take,
  output logic             out_valid,
  input  logic             out_ready,
  output sfd_pkg::pix_t    edge_res,
  output logic             last_of_frame
);

  logic            mag_valid;
  logic            mag_last;
  sfd_pkg::mag_t   mag [4];
  sfd_pkg::mag_t   mag_next [4];
  sfd_pkg::mag_t   max_a;
  sfd_pkg::mag_t   max_b;
  sfd_pkg::mag_t   max_all;
  logic            out_free;

  assign out_free = !out_valid || out_ready;
  assign win_take = !mag_valid || out_free;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      mag_next[k] = sfd_pkg::magnitude(sfd_pkg::kernel_response(win, k));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mag_valid <= 1'b0;
    end else if (win_take) begin
      mag_valid <= win_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (win_take && win_valid) begin
      mag      <= mag_next;
      mag_last <= win_last;
    end
  end

  always_comb begin
    max_a   = (mag[0] > mag[1]) ? mag[0] : mag[1];
    max_b   = (mag[2] > mag[3]) ? mag[2] : mag[3];
    max_all = (max_a > max_b) ? max_a : max_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= mag_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && mag_valid) begin
      edge_res      <= (max_all > sfd_pkg::EDGE_MAX) ? sfd_pkg::PIX_W'(sfd_pkg::EDGE_MAX)
                                                     : max_all[sfd_pkg::PIX_W-1:0];
      last_of_frame <= mag_last;
    end
  end

endmodule

@@ src/sobel_four_direction_max_edge.sv @@
// Top level of the four-direction Sobel edge detector.
// Grey pixels enter in raster order at one per clock while out_ready holds, and each
// interior pixel yields one edge byte, the largest absolute response of four 3x3
// kernels clamped to 255, via the s1, window, magnitude and output registers; border
// rows and columns give nothing, and last_of_frame marks the final result of a frame.
// That rate is set by the line store, a single memory of MAX_WIDTH entries holding the
// two previous rows side by side, read once at acceptance and written back once on
// leaving s1. Widths and heights outside 3..MAX are saturated, and writing either size
// register restarts the frame; write them only while the block is idle. The line store
// needs no clearing after reset, since a frame's first two rows give no result.
module sobel_four_direction_max_edge #(
  parameter int MAX_WIDTH  = sfd_pkg::MAX_WIDTH,
  parameter int MAX_HEIGHT = sfd_pkg::MAX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write_en,
  input  logic [sfd_pkg::CFG_IW-1:0]       cfg_index,
  input  logic [sfd_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [sfd_pkg::PIX_W-1:0]        pixel,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [sfd_pkg::PIX_W-1:0]        edge_res,
  output logic                             last_of_frame
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WSW = (CW + 1 > sfd_pkg::CFG_W) ? CW + 1 : sfd_pkg::CFG_W;
  localparam int HSW = (RW + 1 > sfd_pkg::CFG_W) ? RW + 1 : sfd_pkg::CFG_W;
  localparam int COL_LAST_RST =
    ((sfd_pkg::DEF_WIDTH > MAX_WIDTH) ? MAX_WIDTH : sfd_pkg::DEF_WIDTH) - 1;
  localparam int ROW_LAST_RST =
    ((sfd_pkg::DEF_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : sfd_pkg::DEF_HEIGHT) - 1;
  localparam int LS_W = 2 * sfd_pkg::PIX_W;

  logic [CW-1:0]   col_last;
  logic [RW-1:0]   row_last;
  logic [CW-1:0]   col_last_next;
  logic [RW-1:0]   row_last_next;
  logic [WSW-1:0]  cfg_w;
  logic [HSW-1:0]  cfg_h;
  logic [CW-1:0]   col;
  logic [RW-1:0]   row;
  logic            accept;

  logic            s1_valid;
  logic            s1_prod;
  logic            s1_last;
  sfd_pkg::pix_t   s1_px;
  logic [CW-1:0]   s1_col;
  logic [LS_W-1:0] ls_rd;
  logic            s1_move;

  logic             win_valid;
  logic             win_last;
  sfd_pkg::window_t win;
  logic             win_take;
  logic             win_free;

  // Clamp a size register and keep its last index, so the counters compare directly.
  always_comb begin
    cfg_w = WSW'(cfg_data);
    cfg_h = HSW'(cfg_data);
    if (cfg_w < WSW'(sfd_pkg::MIN_SIZE)) begin
      col_last_next = CW'(sfd_pkg::MIN_SIZE - 1);
    end else if (cfg_w > WSW'(MAX_WIDTH)) begin
      col_last_next = CW'(MAX_WIDTH - 1);
    end else begin
      col_last_next = CW'(cfg_w - WSW'(1));
    end
    if (cfg_h < HSW'(sfd_pkg::MIN_SIZE)) begin
      row_last_next = RW'(sfd_pkg::MIN_SIZE - 1);
    end else if (cfg_h > HSW'(MAX_HEIGHT)) begin
      row_last_next = RW'(MAX_HEIGHT - 1);
    end else begin
      row_last_next = RW'(cfg_h - HSW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_last <= CW'(COL_LAST_RST);
      row_last <= RW'(ROW_LAST_RST);
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        sfd_pkg::REG_WIDTH:  col_last <= col_last_next;
        sfd_pkg::REG_HEIGHT: row_last <= row_last_next;
        default: ;
      endcase
    end
  end

  // Ready ripples back from the output so that bubbles anywhere in the pipe get filled.
  assign win_free = !win_valid || win_take;
  assign s1_move  = s1_valid && win_free;
  assign in_ready = !s1_valid || win_free;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst || cfg_write_en) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col == col_last) begin
        col <= '0;
        row <= (row == row_last) ? '0 : row + RW'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  sfd_line_ram #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (LS_W)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (s1_move),
    .wr_addr (s1_col),
    .wr_data ({ls_rd[sfd_pkg::PIX_W-1:0], s1_px}),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (ls_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px   <= pixel;
      s1_col  <= col;
      s1_prod <= (row >= RW'(2)) && (col >= CW'(2));
      s1_last <= (row == row_last) && (col == col_last);
    end
  end

  // Read data sits in the upper half for two rows up and the lower half for one row up.
  always_ff @(posedge clk) begin
    if (rst) begin
      win       <= '0;
      win_valid <= 1'b0;
    end else begin
      if (win_free) begin
        win_valid <= s1_move && s1_prod;
        win_last  <= s1_last;
      end
      if (s1_move) begin
        win[0] <= win[1];
        win[1] <= win[2];
        win[2] <= ls_rd[LS_W-1:sfd_pkg::PIX_W];
        win[3] <= win[4];
        win[4] <= win[5];
        win[5] <= ls_rd[sfd_pkg::PIX_W-1:0];
        win[6] <= win[7];
        win[7] <= win[8];
        win[8] <= s1_px;
      end
    end
  end

  sfd_grad u_grad (
    .clk           (clk),
    .rst           (rst),
    .win_valid     (win_valid),
    .win_last      (win_last),
    .win           (win),
    .win_take      (win_take),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .edge_res      (edge_res),
    .last_of_frame (last_of_frame)
  );

endmodule
